// File: hdl/two_plane_pixel_framebuffer_core_defines.svh
// Assertion macros shared by the framebuffer RTL.
`ifndef TWO_PLANE_PIXEL_FRAMEBUFFER_CORE_DEFINES_SVH
`define TWO_PLANE_PIXEL_FRAMEBUFFER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Delayed implication, checked later than ASSERT_NEXT.
`define ASSERT_AFTER2(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_NOW(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define ASSERT_AFTER2(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hdl/tpf_pkg.sv
// Shared constants, codes and types for the two-plane framebuffer.
`timescale 1ns / 1ps
`default_nettype none

package tpf_pkg;

  localparam int PANEL_WIDTH_DEF  = 400;
  localparam int PANEL_HEIGHT_DEF = 300;

  localparam int PLANE_W = 8;
  localparam int RAM_W   = 2 * PLANE_W;

  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] COL_BLACK = 2'd1;
  localparam logic [1:0] COL_RED   = 2'd2;

  localparam logic PLANE_RED = 1'b1;

  typedef struct packed {
    logic                 hit;
    logic [PLANE_W-1:0]   mask;
  } pix_ctl_t;

  function automatic int plane_addr_w(input int bytes);
    return (bytes > 1) ? $clog2(bytes) : 1;
  endfunction

endpackage

`default_nettype wire

// File: hdl/two_plane_pixel_framebuffer_core.sv
// Top level of the two-plane (black / red) e-paper framebuffer.
`timescale 1ns / 1ps
`default_nettype none
`include "two_plane_pixel_framebuffer_core_defines.svh"

// Both planes live in one 16-bit wide RAM, red in the upper byte and black in
// the lower, one entry per plane byte. The block takes a command when start is
// high and busy is low. A pixel write is a read-modify-write of one entry: the
// command is accepted, the entry is read in the next cycle and written back in
// the one after, if the pixel lies inside the panel. For a byte read,
// read_strobe marks read_data for a single cycle in the state that follows
// the RAM read state, and the receiver cannot stall it. A clear walks the RAM
// one entry per cycle. After reset the same clearing pass runs with busy high.
// The portrait flag is written through the cfg channel, which is always ready.
module two_plane_pixel_framebuffer_core #(
  parameter int PANEL_WIDTH  = tpf_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = tpf_pkg::PANEL_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [1:0]         colour,
  input  logic [13:0]        byte_index,
  input  logic               plane_select,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  output logic               read_strobe,
  output logic [7:0]         read_data
);

  import tpf_pkg::*;

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int PLANE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W      = plane_addr_w(PLANE_BYTES);

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(PLANE_BYTES - 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_PIX_RD   = 3'd1;
  localparam logic [2:0] ST_PIX_WR   = 3'd2;
  localparam logic [2:0] ST_BYTE_RD  = 3'd3;
  localparam logic [2:0] ST_BYTE_OUT = 3'd4;
  localparam logic [2:0] ST_CLR      = 3'd5;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic               accept;
  logic               portrait;
  logic [1:0]         colour_q;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_hit;
  logic               rd_plane;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  clr_cnt;
  logic [31:0]        bidx_wide;

  pix_ctl_t           pix_ctl;
  logic [ADDR_W-1:0]  pix_idx;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [RAM_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [RAM_W-1:0]   ram_rdata;
  logic [PLANE_W-1:0] black_new;
  logic [PLANE_W-1:0] red_new;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign bidx_wide = 32'(byte_index);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_PIXEL: state_next = ST_PIX_RD;
            OP_CLEAR: state_next = ST_CLR;
            OP_READ:  state_next = ST_BYTE_RD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_PIX_RD:   state_next = ST_PIX_WR;
      ST_PIX_WR:   state_next = ST_IDLE;
      ST_BYTE_RD:  state_next = ST_BYTE_OUT;
      ST_BYTE_OUT: state_next = ST_IDLE;
      ST_CLR: begin
        if (clr_cnt == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_cnt  <= '0;
      portrait <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        portrait <= cfg_data;
      end
      if (accept) begin
        clr_cnt <= '0;
      end else if (state == ST_CLR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      colour_q <= colour;
      rd_addr  <= bidx_wide[ADDR_W-1:0];
      rd_hit   <= bidx_wide < 32'(PLANE_BYTES);
      rd_plane <= plane_select;
    end
    if (state == ST_PIX_RD) begin
      wr_addr <= pix_idx;
    end
  end

  tpf_pix #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .ADDR_W       (ADDR_W)
  ) u_pix (
    .clk      (clk),
    .load     (accept),
    .portrait (portrait),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .ctl      (pix_ctl),
    .idx      (pix_idx)
  );

  // read-modify-write of one pixel: clear both bits, then set the bit of the colour if black or red
  always_comb begin
    black_new = (ram_rdata[PLANE_W-1:0] & ~pix_ctl.mask)
              | ((colour_q == COL_BLACK) ? pix_ctl.mask : '0);
    red_new   = (ram_rdata[RAM_W-1:PLANE_W] & ~pix_ctl.mask)
              | ((colour_q == COL_RED) ? pix_ctl.mask : '0);
  end

  assign ram_we    = (state == ST_CLR) || ((state == ST_PIX_WR) && pix_ctl.hit);
  assign ram_waddr = (state == ST_CLR) ? clr_cnt : wr_addr;
  assign ram_wdata = (state == ST_CLR) ? '0 : {red_new, black_new};
  assign ram_raddr = (state == ST_PIX_RD) ? pix_idx : rd_addr;

  tpf_ram #(
    .WIDTH (RAM_W),
    .DEPTH (PLANE_BYTES),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign read_strobe = (state == ST_BYTE_OUT);

  always_comb begin
    read_data = '0;
    if (read_strobe && rd_hit) begin
      read_data = (rd_plane == PLANE_RED) ? ram_rdata[RAM_W-1:PLANE_W]
                                          : ~ram_rdata[PLANE_W-1:0];
    end
  end

  `ASSERT_AFTER2(a_read_result, clk, rst, accept && (op == OP_READ), read_strobe)
  `ASSERT_NEXT(a_clear_busy, clk, rst, accept && (op == OP_CLEAR), busy && ram_we)
  `ASSERT_NOW(a_no_write_on_result, clk, rst, read_strobe, !ram_we)
  `ASSERT_NOW(a_clear_in_range, clk, rst, state == ST_CLR, clr_cnt <= CLR_LAST)

endmodule

`default_nettype wire

// File: hdl/tpf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tpf_ram #(
  parameter int WIDTH = tpf_pkg::RAM_W,
  parameter int DEPTH = tpf_pkg::PANEL_HEIGHT_DEF,
  parameter int AW    = tpf_pkg::plane_addr_w(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/tpf_pix.sv
// Pixel coordinate check, portrait rotation and byte address / bit mask generation.
`timescale 1ns / 1ps
`default_nettype none

module tpf_pix #(
  parameter int PANEL_WIDTH  = tpf_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = tpf_pkg::PANEL_HEIGHT_DEF,
  parameter int ADDR_W       = tpf_pkg::plane_addr_w(((PANEL_WIDTH + 7) / 8) * PANEL_HEIGHT)
) (
  input  logic                clk,
  input  logic                load,
  input  logic                portrait,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  output tpf_pkg::pix_ctl_t   ctl,
  output logic [ADDR_W-1:0]   idx
);

  import tpf_pkg::*;

  localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
  localparam int PX_W      = $clog2(PANEL_WIDTH);
  localparam int PY_W      = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;

  logic [11:0]     vw;
  logic [11:0]     vh;
  logic            x_ok;
  logic            y_ok;
  logic            hit;
  logic            hit_next;
  logic [PX_W-1:0] px;
  logic [PX_W-1:0] px_next;
  logic [PY_W-1:0] py;
  logic [PY_W-1:0] py_next;

  always_comb begin
    vw = portrait ? 12'(PANEL_HEIGHT) : 12'(PANEL_WIDTH);
    vh = portrait ? 12'(PANEL_WIDTH)  : 12'(PANEL_HEIGHT);
    x_ok = !pos_x[15] && (pos_x[14:0] < {3'b000, vw});
    y_ok = !pos_y[15] && (pos_y[14:0] < {3'b000, vh});
    hit_next = x_ok && y_ok;
    if (portrait) begin
      px_next = pos_y[PX_W-1:0];
      py_next = PY_W'(PANEL_HEIGHT - 1) - pos_x[PY_W-1:0];
    end else begin
      px_next = pos_x[PX_W-1:0];
      py_next = pos_y[PY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px  <= px_next;
      py  <= py_next;
      hit <= hit_next;
    end
  end

  assign ctl.hit  = hit;
  assign ctl.mask = 8'h80 >> px[2:0];
  assign idx      = ADDR_W'(32'(px >> 3) + 32'(py) * 32'(ROW_BYTES));

endmodule

`default_nettype wire

// File: tb/tb_two_plane_pixel_framebuffer_core.sv
// Testbench for the two-plane pixel framebuffer: directed table, then random commands.
`timescale 1ns / 1ps

module tb_two_plane_pixel_framebuffer_core;
  import tpf_pkg::*;

  localparam int ROW_BYTES    = (PANEL_WIDTH_DEF + 7) / 8;
  localparam int PLANE_BYTES  = ROW_BYTES * PANEL_HEIGHT_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] COL_WHITE = 2'd0;
  localparam logic [1:0] COL_SPARE = 2'd3;
  localparam logic PLANE_BLACK = 1'b0;
  localparam int RANDOM_ITEMS = 1090;
  localparam int PHASES       = 6;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [1:0]         col;
    logic [13:0]        idx;
    logic               pl;
    logic               typed;
    logic [7:0]         val;
  } fb_cmd_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         op = OP_PIXEL;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic [1:0]         colour = COL_WHITE;
  logic [13:0]        byte_index = '0;
  logic               plane_select = PLANE_BLACK;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;
  logic               read_strobe;
  logic [7:0]         read_data;

  two_plane_pixel_framebuffer_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .pos_x(pos_x), .pos_y(pos_y), .colour(colour), .byte_index(byte_index),
    .plane_select(plane_select), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .read_strobe(read_strobe), .read_data(read_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  logic [7:0] black_mem [PLANE_BYTES];
  logic [7:0] red_mem   [PLANE_BYTES];
  bit         portrait;
  logic [7:0] expected_bytes [$];
  int         recent_idx [$];
  int         fail_count = 0;
  int         clears_left = 6;
  fb_cmd_t    directed [$];

  function automatic fb_cmd_t mk(input logic [1:0] o, input int xv, input int yv,
                                 input logic [1:0] cv, input int iv, input logic pv,
                                 input logic tv, input logic [7:0] vv);
    fb_cmd_t c;
    c.op = o;
    c.x = xv[15:0];
    c.y = yv[15:0];
    c.col = cv;
    c.idx = iv[13:0];
    c.pl = pv;
    c.typed = tv;
    c.val = vv;
    return c;
  endfunction

  task automatic clear_planes();
    for (int i = 0; i < PLANE_BYTES; i++) begin
      black_mem[i] = 8'h00;
      red_mem[i]   = 8'h00;
    end
  endtask

  // Byte address of a virtual pixel, or -1 when it falls outside the virtual size.
  function automatic int locate_pixel(input logic signed [15:0] x, input logic signed [15:0] y,
                                      output logic [7:0] mask);
    int xi, yi, vw, vh, px, py;
    xi = int'(x);
    yi = int'(y);
    vw = portrait ? PANEL_HEIGHT_DEF : PANEL_WIDTH_DEF;
    vh = portrait ? PANEL_WIDTH_DEF : PANEL_HEIGHT_DEF;
    mask = 8'h00;
    if (xi < 0 || xi >= vw || yi < 0 || yi >= vh) return -1;
    if (portrait) begin
      px = yi;
      py = PANEL_HEIGHT_DEF - 1 - xi;
    end else begin
      px = xi;
      py = yi;
    end
    mask = 8'h80 >> (px % 8);
    return px / 8 + py * ROW_BYTES;
  endfunction

  function automatic logic [7:0] panel_byte(input logic [13:0] idx, input logic pl);
    if (idx >= PLANE_BYTES) return 8'h00;
    return (pl == PLANE_RED) ? red_mem[idx] : ~black_mem[idx];
  endfunction

  task automatic apply_cmd(input fb_cmd_t c);
    int k;
    logic [7:0] m;
    case (c.op)
      OP_PIXEL: begin
        k = locate_pixel(c.x, c.y, m);
        if (k >= 0) begin
          black_mem[k] = black_mem[k] & ~m;
          red_mem[k]   = red_mem[k] & ~m;
          if (c.col == COL_BLACK) black_mem[k] = black_mem[k] | m;
          else if (c.col == COL_RED) red_mem[k] = red_mem[k] | m;
          recent_idx.push_back(k);
          if (recent_idx.size() > 32) void'(recent_idx.pop_front());
        end
      end
      OP_CLEAR: clear_planes();
      OP_READ: expected_bytes.push_back(c.typed ? c.val : panel_byte(c.idx, c.pl));
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] pick_coord(input int span);
    int r;
    logic signed [15:0] v;
    r = $urandom_range(0, 99);
    v = 16'($urandom);
    if (r < 80) begin
      v = 16'($urandom_range(0, span - 1));
    end else if (r < 88) begin
      case ($urandom_range(0, 3))
        0: v = -16'sd1;
        1: v = 16'sd0;
        2: v = 16'(span - 1);
        default: v = 16'(span);
      endcase
    end
    return v;
  endfunction

  function automatic fb_cmd_t random_cmd();
    fb_cmd_t c;
    int r, s;
    c = '0;
    c.x = 16'($urandom);
    c.y = 16'($urandom);
    c.col = 2'($urandom);
    c.idx = 14'($urandom);
    c.pl = 1'($urandom);
    r = $urandom_range(0, 99);
    if (clears_left > 0 && $urandom_range(0, 149) == 0) begin
      c.op = OP_CLEAR;
      clears_left--;
    end else if (r < 3) begin
      c.op = OP_UNUSED;
    end else if (r < 58) begin
      c.op = OP_PIXEL;
      c.x = pick_coord(portrait ? PANEL_HEIGHT_DEF : PANEL_WIDTH_DEF);
      c.y = pick_coord(portrait ? PANEL_WIDTH_DEF : PANEL_HEIGHT_DEF);
    end else begin
      c.op = OP_READ;
      s = $urandom_range(0, 9);
      if (s < 6 && recent_idx.size() > 0)
        c.idx = 14'(recent_idx[$urandom_range(0, recent_idx.size() - 1)]);
      else if (s < 9)
        c.idx = 14'($urandom_range(0, PLANE_BYTES - 1));
    end
    return c;
  endfunction

  // Drive one command word and hold it until the block takes it.
  task automatic issue(input fb_cmd_t c);
    start <= 1'b1;
    op <= c.op;
    pos_x <= c.x;
    pos_y <= c.y;
    colour <= c.col;
    byte_index <= c.idx;
    plane_select <= c.pl;
    do @(posedge clk); while (busy);
    apply_cmd(c);
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_portrait(input bit m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    portrait = m;
  endtask

  always @(posedge clk) begin
    if (!rst && read_strobe) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected read word, expected none, actual %02h", $time, read_data);
        fail_count++;
      end else if (expected_bytes[0] !== read_data) begin
        $display("%0t: read_data mismatch, expected %02h, actual %02h",
                 $time, expected_bytes[0], read_data);
        fail_count++;
        void'(expected_bytes.pop_front());
      end else begin
        void'(expected_bytes.pop_front());
      end
    end
  end

  initial begin
    bit phase_mode [PHASES];
    int done;
    int waited;
    fb_cmd_t c;

    phase_mode = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    clear_planes();
    portrait = 1'b0;
    directed.push_back(mk(OP_READ, 0, 0, COL_WHITE, 0, PLANE_BLACK, 1'b1, 8'hFF));
    directed.push_back(mk(OP_READ, 0, 0, COL_WHITE, PLANE_BYTES - 1, PLANE_RED, 1'b1, 8'h00));
    directed.push_back(mk(OP_READ, 0, 0, COL_WHITE, PLANE_BYTES, PLANE_BLACK, 1'b1, 8'h00));
    directed.push_back(mk(OP_READ, 0, 0, COL_WHITE, 16383, PLANE_RED, 1'b1, 8'h00));
    directed.push_back(mk(OP_PIXEL, 0, 0, COL_BLACK, 0, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_PIXEL, 399, 299, COL_RED, 0, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_PIXEL, -1, 0, COL_BLACK, 0, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_PIXEL, 400, 5, COL_BLACK, 0, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_PIXEL, 3, 300, COL_RED, 0, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_PIXEL, -32768, 32767, COL_RED, 0, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_PIXEL, 32767, -32768, COL_BLACK, 0, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_PIXEL, 1, 0, COL_BLACK, 0, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_PIXEL, 1, 0, COL_SPARE, 0, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_PIXEL, 7, 0, COL_RED, 0, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_READ, 0, 0, COL_WHITE, 0, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_READ, 0, 0, COL_WHITE, 0, PLANE_RED, 1'b0, 8'h00));
    directed.push_back(mk(OP_READ, 0, 0, COL_WHITE, PLANE_BYTES - 1, PLANE_RED, 1'b0, 8'h00));
    directed.push_back(mk(OP_READ, 0, 0, COL_WHITE, PLANE_BYTES - 1, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_UNUSED, 0, 0, COL_WHITE, 0, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_PIXEL, 0, 0, COL_RED, 0, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_PIXEL, 8, 1, COL_WHITE, 0, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_READ, 0, 0, COL_WHITE, 0, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_CLEAR, 0, 0, COL_WHITE, 0, PLANE_BLACK, 1'b0, 8'h00));
    directed.push_back(mk(OP_READ, 0, 0, COL_WHITE, 0, PLANE_RED, 1'b1, 8'h00));
    directed.push_back(mk(OP_READ, 0, 0, COL_WHITE, PLANE_BYTES - 1, PLANE_BLACK, 1'b1, 8'hFF));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_portrait(1'b0);

    foreach (directed[i]) begin
      issue(directed[i]);
      if ($urandom_range(0, 99) < 8) hold_off($urandom_range(1, 6));
    end

    done = 0;
    for (int p = 0; p < PHASES; p++) begin
      set_portrait(phase_mode[p]);
      while (done < (p + 1) * RANDOM_ITEMS / PHASES) begin
        c = random_cmd();
        issue(c);
        if (c.op != OP_UNUSED) done++;
        // quiet stretch: back-to-back words
        if ((done < 400 || done >= 650) && $urandom_range(0, 99) < 8)
          hold_off($urandom_range(1, 6));
      end
    end

    start <= 1'b0;
    waited = 0;
    while (expected_bytes.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $display("%0t: %0d read words never arrived, expected %02h, actual none",
               $time, expected_bytes.size(), expected_bytes[0]);
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
